// ===== rtl/vcd_pkg.sv =====
package vcd_pkg;

    // Widths of the internal counters and indexes
    localparam int POS_W       = 8;
    localparam int FIELD_IDX_W = 4;
    localparam int NUM_FIELDS  = 11;
    localparam int CFG_IDX_W   = 1;

    // Defaults for the top-level parameters
    localparam int DEF_HEADER_BYTES = 64;
    localparam int DEF_RECORD_BYTES = 16;

    // File header layout
    localparam logic [POS_W-1:0] SIG_LEN         = 8'd6;
    localparam logic [POS_W-1:0] HDR_FIELD_FIRST = 8'd8;
    localparam logic [POS_W-1:0] HDR_FIELD_END   = 8'd52;

    // Record header layout: byte groups of four
    localparam logic [POS_W-3:0] REC_GRP_SIZE  = 6'd0;
    localparam logic [POS_W-3:0] REC_GRP_QIDX  = 6'd1;
    localparam logic [POS_W-3:0] REC_GRP_FLAGS = 6'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DROPPED_MARKER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 1'b1;

    localparam logic signed [31:0] RST_DROPPED_MARKER  = -32'sd1;
    localparam logic        [31:0] RST_MAX_FRAME_BYTES = 32'd16777216;

    // Result kinds
    localparam logic [1:0] KIND_FIELD   = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_MAGIC     = 2'd0;
    localparam logic [1:0] ERR_ZERO_DIM  = 2'd1;
    localparam logic [1:0] ERR_DROP_SIZE = 2'd2;
    localparam logic [1:0] ERR_BAD_SIZE  = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_EMIT,
        PH_RECORD,
        PH_PAYLOAD,
        PH_ERROR
    } t_phase;

    // One byte-lane write into the header word store
    typedef struct packed {
        logic                   we;
        logic [FIELD_IDX_W-1:0] idx;
        logic [1:0]             lane;
        logic [7:0]             data;
    } t_hdr_wr;

    // One result item
    typedef struct packed {
        logic [1:0]             kind;
        logic [FIELD_IDX_W-1:0] field_index;
        logic [31:0]            field_value;
        logic [31:0]            frame_len;
        logic signed [31:0]     q_index;
        logic [31:0]            frame_flags;
        logic                   dropped;
        logic [7:0]             payload_byte;
        logic                   last;
        logic [1:0]             error_code;
    } t_result;

    // Signature bytes: "MLVC1" then version 0x02
    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'h4D;
            3'd1:    b = 8'h4C;
            3'd2:    b = 8'h56;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h31;
            3'd5:    b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/vcd_in_stage.sv =====
module vcd_in_stage import vcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_consume
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Take a new request whenever the held one is empty or leaves this cycle
    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== rtl/vcd_hdr_store.sv =====
module vcd_hdr_store import vcd_pkg::*; (
    input  logic                   i_clk,
    input  t_hdr_wr                i_wr,
    input  logic [FIELD_IDX_W-1:0] i_rd_idx,
    output logic [31:0]            o_rd_data
);

    logic [31:0] r_words [NUM_FIELDS];

    // Write one byte lane of a header word
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_words[i_wr.idx][{i_wr.lane, 3'b000} +: 8] <= i_wr.data;
        end
    end

    assign o_rd_data = r_words[i_rd_idx];

endmodule

// ===== rtl/vcd_parser.sv =====
module vcd_parser import vcd_pkg::*; #(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int RECORD_BYTES = DEF_RECORD_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [7:0]             i_in_byte,
    output logic                   o_consume,
    input  logic signed [31:0]     i_dropped_marker,
    input  logic [31:0]            i_max_frame_bytes,
    output t_hdr_wr                o_hdr_wr,
    output logic [FIELD_IDX_W-1:0] o_rd_idx,
    input  logic [31:0]            i_rd_data,
    output t_result                o_res,
    output logic                   o_res_valid,
    input  logic                   i_res_ready
);

    localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] REC_LAST = POS_W'(RECORD_BYTES - 1);
    localparam logic [FIELD_IDX_W-1:0] FIELD_LAST = FIELD_IDX_W'(NUM_FIELDS - 1);

    function automatic logic [31:0] put_byte(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        w[{lane, 3'b000} +: 8] = b;
        return w;
    endfunction

    t_phase                 r_phase, n_phase;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [31:0]            r_remaining, n_remaining;
    logic                   r_magic_ok, n_magic_ok;
    logic                   r_w_nz, n_w_nz;
    logic                   r_h_nz, n_h_nz;
    logic [FIELD_IDX_W-1:0] r_emit_idx, n_emit_idx;
    logic [31:0]            r_rec_size, n_rec_size;
    logic signed [31:0]     r_rec_q, n_rec_q;
    logic [31:0]            r_rec_flags, n_rec_flags;
    logic                   r_res_valid, n_res_valid;
    t_result                r_res, n_res;

    logic                   load_ok;
    logic                   consume;
    logic                   magic_now;
    logic                   hdr_last;
    logic                   rec_last;
    logic                   in_fields;
    logic [POS_W-1:0]       hdr_off;
    logic [FIELD_IDX_W-1:0] hdr_idx;
    logic                   is_drop;
    logic                   size_bad;
    logic                   pay_last;
    logic                   emit_last;

    // Shared decode of the current byte and state
    assign load_ok   = !r_res_valid || i_res_ready;
    assign consume   = i_in_valid &&
                       (r_phase == PH_ERROR || (load_ok && r_phase != PH_EMIT));
    assign magic_now = r_magic_ok &&
                       !(r_pos < SIG_LEN && i_in_byte != sig_byte(r_pos[2:0]));
    assign hdr_last  = r_pos == HDR_LAST;
    assign rec_last  = r_pos == REC_LAST;
    assign in_fields = r_pos >= HDR_FIELD_FIRST && r_pos < HDR_FIELD_END;
    assign hdr_off   = r_pos - HDR_FIELD_FIRST;
    assign hdr_idx   = hdr_off[FIELD_IDX_W+1:2];
    assign is_drop   = r_rec_q == i_dropped_marker;
    assign size_bad  = r_rec_size == 32'd0 || r_rec_size > i_max_frame_bytes;
    assign pay_last  = r_remaining <= 32'd1;
    assign emit_last = r_emit_idx == FIELD_LAST;

    assign o_consume   = consume;
    assign o_rd_idx    = r_emit_idx;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEADER: begin
                if (consume && hdr_last) begin
                    if (!magic_now || !(r_w_nz && r_h_nz)) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_phase = PH_EMIT;
                    end
                end
            end
            PH_EMIT: begin
                if (load_ok && emit_last) begin
                    n_phase = PH_RECORD;
                end
            end
            PH_RECORD: begin
                if (consume && rec_last) begin
                    if (is_drop) begin
                        n_phase = (r_rec_size != 32'd0) ? PH_ERROR : PH_RECORD;
                    end else if (size_bad) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (consume && pay_last) begin
                    n_phase = PH_RECORD;
                end
            end
            PH_ERROR: begin
                n_phase = PH_ERROR;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    // Datapath and result for the current byte
    always_comb begin
        n_pos       = r_pos;
        n_remaining = r_remaining;
        n_magic_ok  = r_magic_ok;
        n_w_nz      = r_w_nz;
        n_h_nz      = r_h_nz;
        n_emit_idx  = r_emit_idx;
        n_rec_size  = r_rec_size;
        n_rec_q     = r_rec_q;
        n_rec_flags = r_rec_flags;
        n_res_valid = 1'b0;
        n_res       = '0;
        o_hdr_wr    = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (consume) begin
                    n_magic_ok = magic_now;
                    // Gather the header words and note nonzero dimensions
                    if (in_fields) begin
                        o_hdr_wr.we   = 1'b1;
                        o_hdr_wr.idx  = hdr_idx;
                        o_hdr_wr.lane = r_pos[1:0];
                        o_hdr_wr.data = i_in_byte;
                        if (hdr_idx == FIELD_IDX_W'(0) && i_in_byte != 8'd0) begin
                            n_w_nz = 1'b1;
                        end
                        if (hdr_idx == FIELD_IDX_W'(1) && i_in_byte != 8'd0) begin
                            n_h_nz = 1'b1;
                        end
                    end
                    if (hdr_last) begin
                        n_pos      = '0;
                        n_emit_idx = '0;
                        if (!magic_now) begin
                            n_res_valid      = 1'b1;
                            n_res.kind       = KIND_ERROR;
                            n_res.error_code = ERR_MAGIC;
                        end else if (!(r_w_nz && r_h_nz)) begin
                            n_res_valid      = 1'b1;
                            n_res.kind       = KIND_ERROR;
                            n_res.error_code = ERR_ZERO_DIM;
                        end
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            PH_EMIT: begin
                // Send one header field per cycle while the result register can load
                if (load_ok) begin
                    n_res_valid       = 1'b1;
                    n_res.kind        = KIND_FIELD;
                    n_res.field_index = r_emit_idx;
                    n_res.field_value = i_rd_data;
                    n_res.last        = emit_last;
                    n_emit_idx        = r_emit_idx + FIELD_IDX_W'(1);
                end
            end
            PH_RECORD: begin
                if (consume) begin
                    case (r_pos[POS_W-1:2])
                        REC_GRP_SIZE:
                            n_rec_size = put_byte(r_rec_size, r_pos[1:0], i_in_byte);
                        REC_GRP_QIDX:
                            n_rec_q = put_byte(r_rec_q, r_pos[1:0], i_in_byte);
                        REC_GRP_FLAGS:
                            n_rec_flags = put_byte(r_rec_flags, r_pos[1:0], i_in_byte);
                        default: ;
                    endcase
                    if (rec_last) begin
                        n_pos = '0;
                        if (is_drop && r_rec_size != 32'd0) begin
                            n_res_valid      = 1'b1;
                            n_res.kind       = KIND_ERROR;
                            n_res.error_code = ERR_DROP_SIZE;
                        end else if (is_drop) begin
                            n_res_valid       = 1'b1;
                            n_res.kind        = KIND_RECORD;
                            n_res.q_index     = r_rec_q;
                            n_res.frame_flags = r_rec_flags;
                            n_res.dropped     = 1'b1;
                            n_res.last        = 1'b1;
                        end else if (size_bad) begin
                            n_res_valid      = 1'b1;
                            n_res.kind       = KIND_ERROR;
                            n_res.error_code = ERR_BAD_SIZE;
                        end else begin
                            n_res_valid       = 1'b1;
                            n_res.kind        = KIND_RECORD;
                            n_res.frame_len   = r_rec_size;
                            n_res.q_index     = r_rec_q;
                            n_res.frame_flags = r_rec_flags;
                            n_remaining       = r_rec_size;
                        end
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            PH_PAYLOAD: begin
                // Pass payload bytes and mark the final one
                if (consume) begin
                    n_res_valid        = 1'b1;
                    n_res.kind         = KIND_PAYLOAD;
                    n_res.payload_byte = i_in_byte;
                    n_res.last         = pay_last;
                    if (pay_last) begin
                        n_remaining = '0;
                        n_pos       = '0;
                    end else begin
                        n_remaining = r_remaining - 32'd1;
                    end
                end
            end
            PH_ERROR: begin
                // Drop everything until reset
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= '0;
            r_remaining <= '0;
            r_magic_ok  <= 1'b1;
            r_w_nz      <= 1'b0;
            r_h_nz      <= 1'b0;
            r_emit_idx  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_remaining <= n_remaining;
            r_magic_ok  <= n_magic_ok;
            r_w_nz      <= n_w_nz;
            r_h_nz      <= n_h_nz;
            r_emit_idx  <= n_emit_idx;
            if (load_ok) begin
                r_res_valid <= n_res_valid;
            end
        end
    end

    // Record words and result payload
    always_ff @(posedge i_clk) begin
        r_rec_size  <= n_rec_size;
        r_rec_q     <= n_rec_q;
        r_rec_flags <= n_rec_flags;
        if (load_ok) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== rtl/video_container_demux_unit.sv =====
// A byte's result is loaded into the result register at the edge at which the parser
// consumes the byte from the input register; a stall can hold the byte there.
// Throughput: one byte per cycle while the result is not stalled; the eleven header
// fields leave one per cycle, likewise unless stalled, after the last file header byte,
// and input is held while they are sent. A stalled result holds the input as well.
// Reset (synchronous, active low) returns to the file header, clears errors,
// empties both registers and restores the configuration defaults.
module video_container_demux_unit import vcd_pkg::*; #(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int RECORD_BYTES = DEF_RECORD_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_data_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_kind,
    output logic [FIELD_IDX_W-1:0] o_field_index,
    output logic [31:0]            o_field_value,
    output logic [31:0]            o_frame_len,
    output logic signed [31:0]     o_q_index,
    output logic [31:0]            o_frame_flags,
    output logic                   o_dropped,
    output logic [7:0]             o_payload_byte,
    output logic                   o_last,
    output logic [1:0]             o_error_code
);

    logic signed [31:0]     r_dropped_marker;
    logic [31:0]            r_max_frame_bytes;

    logic                   st_valid;
    logic [7:0]             st_byte;
    logic                   consume;
    t_hdr_wr                hdr_wr;
    logic [FIELD_IDX_W-1:0] rd_idx;
    logic [31:0]            rd_data;
    t_result                res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dropped_marker  <= RST_DROPPED_MARKER;
            r_max_frame_bytes <= RST_MAX_FRAME_BYTES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DROPPED_MARKER:  r_dropped_marker  <= i_cfg_data;
                CFG_MAX_FRAME_BYTES: r_max_frame_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vcd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_byte    (i_data_byte),
        .o_ready   (o_in_ready),
        .o_valid   (st_valid),
        .o_byte    (st_byte),
        .i_consume (consume)
    );

    vcd_hdr_store u_hdr_store (
        .i_clk     (i_clk),
        .i_wr      (hdr_wr),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    vcd_parser #(
        .HEADER_BYTES (HEADER_BYTES),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (st_valid),
        .i_in_byte         (st_byte),
        .o_consume         (consume),
        .i_dropped_marker  (r_dropped_marker),
        .i_max_frame_bytes (r_max_frame_bytes),
        .o_hdr_wr          (hdr_wr),
        .o_rd_idx          (rd_idx),
        .i_rd_data         (rd_data),
        .o_res             (res),
        .o_res_valid       (o_out_valid),
        .i_res_ready       (i_out_ready)
    );

    // Unpack the result register onto the ports
    assign o_kind         = res.kind;
    assign o_field_index  = res.field_index;
    assign o_field_value  = res.field_value;
    assign o_frame_len    = res.frame_len;
    assign o_q_index      = res.q_index;
    assign o_frame_flags  = res.frame_flags;
    assign o_dropped      = res.dropped;
    assign o_payload_byte = res.payload_byte;
    assign o_last         = res.last;
    assign o_error_code   = res.error_code;

endmodule
